>>> rtl/core/etpd_pkg.sv
// Package for the exclusive-time-per-depth block.
// Holds the field widths, the default depth count and the control state type.
// No dependencies.
`timescale 1ns / 1ps

package etpd_pkg;

  localparam int unsigned TimeW       = 64;
  localparam int unsigned DepthW      = 8;
  localparam int unsigned MaxDepthDef = 256;

  typedef logic [TimeW-1:0]  time_t;
  typedef logic [DepthW-1:0] depth_t;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StCalc = 2'b10
  } state_e;

endpackage

>>> rtl/core/etpd_if.sv
// Valid/ready channel interfaces for trace records and exclusive-time results.
// Depends on etpd_pkg for the payload types.
`timescale 1ns / 1ps

interface etpd_in_if;
  import etpd_pkg::*;

  logic   valid;
  logic   ready;
  logic   first_of_window;
  time_t  start_time;
  time_t  end_time;
  depth_t call_depth;

  modport source (output valid, first_of_window, start_time, end_time, call_depth,
                  input ready);
  modport sink   (input valid, first_of_window, start_time, end_time, call_depth,
                  output ready);
endinterface

interface etpd_out_if;
  import etpd_pkg::*;

  logic  valid;
  logic  ready;
  time_t exclusive_time;
  logic  went_negative;

  modport source (output valid, exclusive_time, went_negative, input ready);
  modport sink   (input valid, exclusive_time, went_negative, output ready);
endinterface

>>> rtl/core/exclusive_time_per_depth.sv
// Channel    | Dir | Payload                                          | Transfer
// in_i       | in  | first_of_window, start_time, end_time, call_depth | valid & ready
// out_o      | out | exclusive_time, went_negative                     | valid & ready
//
// The totals memory is read at the input transfer, and the read-modify-write of one depth
// total completes in StCalc, which waits while the output slot is full; no new record is
// accepted until it is done. Reset clears the per-depth valid bits, so the totals read as
// zero with no clearing pass; a window start and skipped levels clear them the same way.
// A stalled output holds its result in the output register; the next record is still
// accepted, and the block then waits with its result until the output slot frees.
// Depends on etpd_pkg and the interfaces in etpd_if.sv.
`timescale 1ns / 1ps

module exclusive_time_per_depth #(
  parameter int unsigned MAX_DEPTH = etpd_pkg::MaxDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  etpd_in_if.sink     in_i,
  etpd_out_if.source  out_o
);
  import etpd_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_DEPTH);
  localparam int unsigned CmpW = (IdxW > DepthW) ? IdxW : DepthW;

  typedef logic [IdxW-1:0] idx_t;

  // Totals memory: two read ports, one write port, registered read data.
  time_t mem_q [MAX_DEPTH];
  time_t rd_d_q;
  time_t rd_p_q;

  state_e              state_q, state_d;
  idx_t                prev_q, prev_d;
  logic [MAX_DEPTH-1:0] valid_q, valid_d;
  logic                out_valid_q, out_valid_d;

  logic  first_q;
  time_t dur_q;
  idx_t  depth_q;
  time_t exclusive_time_q;
  logic  went_negative_q;

  logic [CmpW-1:0] depth_ext;
  idx_t            depth_in;
  logic            accept;
  logic            out_free;
  logic            finish;

  idx_t  prev_eff;
  time_t tot_d;
  time_t tot_p;
  time_t wr_data;
  time_t excl;
  logic  neg;
  logic  same_lvl;
  logic  deeper;

  // Depths beyond the table saturate at the last entry.
  assign depth_ext = CmpW'(in_i.call_depth);
  assign depth_in  = (depth_ext >= CmpW'(MAX_DEPTH - 1)) ? idx_t'(MAX_DEPTH - 1)
                                                         : idx_t'(depth_ext);

  assign in_i.ready = (state_q == StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign finish     = (state_q == StCalc) && out_free;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_d_q <= mem_q[depth_in];
      rd_p_q <= mem_q[prev_q];
    end
    if (finish) begin
      mem_q[depth_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      first_q <= in_i.first_of_window;
      dur_q   <= in_i.end_time - in_i.start_time;
      depth_q <= depth_in;
    end
    if (finish) begin
      exclusive_time_q <= excl;
      went_negative_q  <= neg;
    end
  end

  // A window start behaves as a same-depth record on an empty table.
  always_comb begin
    prev_eff = first_q ? depth_q : prev_q;
    tot_d    = (valid_q[depth_q] && !first_q) ? rd_d_q : '0;
    tot_p    = (valid_q[prev_eff] && !first_q) ? rd_p_q : '0;
    same_lvl = (depth_q == prev_eff);
    deeper   = (depth_q > prev_eff);
    excl     = dur_q;
    neg      = 1'b0;
    priority if (same_lvl) begin
      wr_data = tot_d + dur_q;
    end else if (deeper) begin
      wr_data = dur_q;
    end else begin
      wr_data = tot_d + dur_q;
      if (tot_p > dur_q) begin
        excl = '0;
        neg  = 1'b1;
      end else begin
        excl = dur_q - tot_p;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    prev_d      = prev_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StCalc;
        end
      end
      StCalc: begin
        if (finish) begin
          state_d     = StIdle;
          prev_d      = depth_q;
          out_valid_d = 1'b1;
          for (int j = 0; j < MAX_DEPTH; j++) begin
            if (first_q) begin
              valid_d[j] = 1'b0;
            end else if (deeper && (idx_t'(j) > prev_eff) && (idx_t'(j) < depth_q)) begin
              valid_d[j] = 1'b0;
            end
            if (idx_t'(j) == depth_q) begin
              valid_d[j] = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prev_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.exclusive_time = exclusive_time_q;
  assign out_o.went_negative  = went_negative_q;

endmodule

>>> test/testbench.sv
// Self-checking testbench for exclusive_time_per_depth: a table of directed trace records,
// then random post-order call sequences, checked against a per-depth model or hand values.
// Depends on etpd_pkg, the channel interfaces in etpd_if.sv and the block itself.
`timescale 1ns / 1ps

module testbench;
  import etpd_pkg::*;

  localparam int unsigned MaxDepth       = MaxDepthDef;
  localparam int unsigned RandomPerPhase = 244;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned DrainCycles    = 10;
  localparam int unsigned ExpSlots       = 16;
  localparam time_t       TimeMax        = '1;

  typedef struct packed {
    logic   first_of_window;
    time_t  start_time;
    time_t  end_time;
    depth_t call_depth;
  } trace_rec_t;

  typedef struct packed {
    time_t exclusive_time;
    logic  went_negative;
  } excl_result_t;

  typedef struct packed {
    logic   first_of_window;
    time_t  start_time;
    time_t  end_time;
    depth_t call_depth;
    logic   typed;
    time_t  exp_time;
    logic   exp_neg;
  } directed_row_t;

  // Rows marked typed carry a result that can be worked out by hand; the rest use the model.
  localparam int unsigned NumDirected = 19;
  directed_row_t directed_rows [NumDirected] = '{
    '{1'b0, 64'd100, 64'd150, 8'd0, 1'b1, 64'd50, 1'b0},   // same depth just after reset
    '{1'b0, 64'd0, 64'd30, 8'd2, 1'b1, 64'd30, 1'b0},      // deeper, skipping depth 1
    '{1'b0, 64'd10, 64'd20, 8'd2, 1'b0, 64'd0, 1'b0},
    '{1'b0, 64'd0, 64'd100, 8'd1, 1'b1, 64'd60, 1'b0},     // parent less its children
    '{1'b0, 64'd0, 64'd50, 8'd0, 1'b1, 64'd0, 1'b1},       // children outlast the parent
    '{1'b0, 64'd0, TimeMax, 8'd255, 1'b1, TimeMax, 1'b0},  // deepest level, longest duration
    '{1'b0, 64'd5, 64'd4, 8'd255, 1'b1, TimeMax, 1'b0},    // end before start, total wraps
    '{1'b0, 64'd0, TimeMax, 8'd0, 1'b1, 64'd1, 1'b0},
    '{1'b1, 64'd1000, 64'd1010, 8'd7, 1'b1, 64'd10, 1'b0}, // window start clears the totals
    '{1'b0, 64'd0, 64'd5, 8'd3, 1'b1, 64'd0, 1'b1},
    '{1'b1, TimeMax, TimeMax, 8'd255, 1'b1, 64'd0, 1'b0},
    '{1'b0, 64'd0, 64'd0, 8'd254, 1'b1, 64'd0, 1'b0},
    '{1'b0, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0040, 8'd254, 1'b0, 64'd0, 1'b0},
    '{1'b0, 64'd0, 64'h5555_5555_5555_5555, 8'd128, 1'b0, 64'd0, 1'b0},
    '{1'b0, 64'd3, 64'd3, 8'd128, 1'b0, 64'd0, 1'b0},
    '{1'b0, 64'd0, 64'd7, 8'd1, 1'b0, 64'd0, 1'b0},
    '{1'b1, 64'd20, 64'd25, 8'd0, 1'b0, 64'd0, 1'b0},
    '{1'b0, 64'd0, 64'd9, 8'd1, 1'b0, 64'd0, 1'b0},
    '{1'b0, 64'd0, 64'd4, 8'd0, 1'b0, 64'd0, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  etpd_in_if  in_bus ();
  etpd_out_if out_bus ();

  exclusive_time_per_depth u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Model state: one running total per depth and the depth of the last record.
  time_t        depth_total [MaxDepth];
  int unsigned  last_depth;

  // Expected results in order of transfer; the sender advances exp_wr, the receiver exp_rd.
  excl_result_t expected_mem [ExpSlots];
  int unsigned  exp_wr;
  int unsigned  exp_rd;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned fail_count;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic excl_result_t account_record(input trace_rec_t r);
    excl_result_t res;
    time_t        dur;
    time_t        child;
    int unsigned  d;
    dur = r.end_time - r.start_time;
    d = (32'(r.call_depth) >= MaxDepth) ? MaxDepth - 1 : 32'(r.call_depth);
    res.exclusive_time = dur;
    res.went_negative  = 1'b0;
    if (r.first_of_window) begin
      foreach (depth_total[j]) depth_total[j] = '0;
      last_depth = d;
    end
    if (d == last_depth) begin
      depth_total[d] += dur;
    end else if (d > last_depth) begin
      for (int unsigned j = last_depth + 1; j < d; j++) depth_total[j] = '0;
      depth_total[d] = dur;
    end else begin
      child = depth_total[last_depth];
      if (child > dur) begin
        res.exclusive_time = '0;
        res.went_negative  = 1'b1;
      end else begin
        res.exclusive_time = dur - child;
      end
      depth_total[d] += dur;
    end
    last_depth = d;
    return res;
  endfunction

  // Mostly a walk of the call depth as a post-order trace would produce, with parents
  // that usually outlast their children; now and then a jump, a window start or odd times.
  function automatic trace_rec_t make_record();
    trace_rec_t  r;
    time_t       dur;
    int unsigned d;
    int unsigned pick;
    pick = $urandom_range(99);
    d = last_depth;
    r.first_of_window = ($urandom_range(99) < 4);
    if (pick < 10) begin
      d = $urandom_range(255);
    end else if (pick < 40) begin
      d = (d > 0) ? d - 1 : 0;
    end else if (pick < 70) begin
      d = d + $urandom_range(1, 2);
    end else if (pick < 75) begin
      d = (d > 3) ? d - $urandom_range(2, 3) : 0;
    end
    if (d > MaxDepth - 1) d = MaxDepth - 1;
    if (d < last_depth && !r.first_of_window && $urandom_range(9) < 8) begin
      dur = depth_total[last_depth] + time_t'($urandom_range(200));
    end else begin
      case ($urandom_range(9))
        0:       dur = {$urandom, $urandom};
        1:       dur = '0;
        default: dur = time_t'($urandom_range(1, 1000));
      endcase
    end
    r.start_time = {$urandom, $urandom};
    r.end_time   = r.start_time + dur;
    r.call_depth = d[DepthW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input time_t got, input time_t want);
    fail_count++;
    if (fail_count <= 100)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Offers one record and waits for its transfer; a hold-off first waits for every
  // outstanding result to come back.
  task automatic offer_record(input trace_rec_t r, input excl_result_t want,
                              input bit hold_off);
    if (hold_off || $urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk_i);
      while ((hold_off && exp_wr != exp_rd) || $urandom_range(99) < send_idle_pct);
    end
    in_bus.valid           <= 1'b1;
    in_bus.first_of_window <= r.first_of_window;
    in_bus.start_time      <= r.start_time;
    in_bus.end_time        <= r.end_time;
    in_bus.call_depth      <= r.call_depth;
    do @(posedge clk_i);
    while (!in_bus.ready);
    expected_mem[exp_wr[3:0]] = want;
    exp_wr++;
  endtask

  initial begin : receiver
    excl_result_t want;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) begin
        if (exp_wr == exp_rd) begin
          report_mismatch("unexpected result", out_bus.exclusive_time, '0);
        end else begin
          want = expected_mem[exp_rd[3:0]];
          exp_rd++;
          if (out_bus.exclusive_time !== want.exclusive_time)
            report_mismatch("exclusive_time", out_bus.exclusive_time, want.exclusive_time);
          if (out_bus.went_negative !== want.went_negative)
            report_mismatch("went_negative", time_t'(out_bus.went_negative),
                            time_t'(want.went_negative));
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : sender
    trace_rec_t   rec;
    excl_result_t want;
    foreach (depth_total[j]) depth_total[j] = '0;
    last_depth    = 0;
    send_idle_pct = 27;
    recv_idle_pct = 85;
    in_bus.valid           <= 1'b0;
    in_bus.first_of_window <= 1'b0;
    in_bus.start_time      <= '0;
    in_bus.end_time        <= '0;
    in_bus.call_depth      <= '0;
    do @(posedge clk_i);
    while (!rst_ni);

    foreach (directed_rows[i]) begin
      rec.first_of_window = directed_rows[i].first_of_window;
      rec.start_time      = directed_rows[i].start_time;
      rec.end_time        = directed_rows[i].end_time;
      rec.call_depth      = directed_rows[i].call_depth;
      want = account_record(rec);
      if (directed_rows[i].typed) begin
        want.exclusive_time = directed_rows[i].exp_time;
        want.went_negative  = directed_rows[i].exp_neg;
      end
      offer_record(rec, want, 1'b0);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RandomPerPhase; n++) begin
        rec  = make_record();
        want = account_record(rec);
        offer_record(rec, want, (phase > 0 && n == 0) || $urandom_range(99) == 0);
      end
    end
    in_bus.valid <= 1'b0;

    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
